// File: hdl/midpoint_ellipse_rasterizer_core_macros.svh
// assertion helpers used by the checker file
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_CORE_MACROS_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MER_ASSERT_IMPLY(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mer: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define MER_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mer: next-cycle check failed");

`endif

// File: hdl/mer_pkg.sv
package mer_pkg;

  // fixed field widths
  localparam int CLIP_BITS     = 16;
  localparam int DIM_BITS      = 15;
  localparam int COLOR_BITS    = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [DIM_BITS-1:0] CANVAS_RESET = 15'd1024;

  // register map, one word each
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_CLIP_LEFT     = 3'd0,
    REG_CLIP_TOP      = 3'd1,
    REG_CLIP_WIDTH    = 3'd2,
    REG_CLIP_HEIGHT   = 3'd3,
    REG_CANVAS_WIDTH  = 3'd4,
    REG_CANVAS_HEIGHT = 3'd5,
    REG_DRAW_COLOR    = 3'd6
  } reg_index_t;

  // item command
  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_t;

  // octant passes, then the two fill regions
  typedef enum logic [3:0] {
    PH_OCT1      = 4'd1,
    PH_OCT2      = 4'd2,
    PH_OCT3      = 4'd3,
    PH_OCT4      = 4'd4,
    PH_OCT5      = 4'd5,
    PH_OCT6      = 4'd6,
    PH_OCT7      = 4'd7,
    PH_OCT8      = 4'd8,
    PH_FILL_TOP  = 4'd9,
    PH_FILL_SIDE = 4'd10
  } phase_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_PRODUCT,
    ST_SETUP,
    ST_RUN
  } ctrl_state_t;

  // configuration register file contents
  typedef struct packed {
    logic signed [CLIP_BITS-1:0] clip_left;
    logic signed [CLIP_BITS-1:0] clip_top;
    logic [DIM_BITS-1:0]         clip_width;
    logic [DIM_BITS-1:0]         clip_height;
    logic [DIM_BITS-1:0]         canvas_width;
    logic [DIM_BITS-1:0]         canvas_height;
    logic [COLOR_BITS-1:0]       draw_color;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture start item fields
    logic square;     // form a^2, b^2
    logic product;    // form b^2*a, a^2*b and 6a^2, 6b^2
    logic update;     // one midpoint step
    logic init;       // load region start values
    logic init_side;  // region of the values to load
    logic cur_side;   // region of the running step
    logic emit;       // load the result register
    logic emit_empty; // result of an empty figure
    logic neg_x;
    logic neg_y;
    logic span;
    logic done;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic more;        // region continues after this step
    logic empty_start; // start item has a zero semi-axis
  } dp_stat_t;

endpackage

// File: hdl/mer_cfg_regs.sv
module mer_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mer_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [mer_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [mer_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                 pready,
  output mer_pkg::cfg_t                        cfg
);

  mer_pkg::cfg_t      cfg_r;
  mer_pkg::reg_index_t idx;
  logic               wr_en;

  assign idx    = mer_pkg::reg_index_t'(paddr[mer_pkg::CFG_ADDR_BITS-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_left     <= '0;
      cfg_r.clip_top      <= '0;
      cfg_r.clip_width    <= '0;
      cfg_r.clip_height   <= '0;
      cfg_r.canvas_width  <= mer_pkg::CANVAS_RESET;
      cfg_r.canvas_height <= mer_pkg::CANVAS_RESET;
      cfg_r.draw_color    <= '0;
    end else if (wr_en) begin
      case (idx)
        mer_pkg::REG_CLIP_LEFT:
          cfg_r.clip_left <= signed'(pwdata[mer_pkg::CLIP_BITS-1:0]);
        mer_pkg::REG_CLIP_TOP:
          cfg_r.clip_top <= signed'(pwdata[mer_pkg::CLIP_BITS-1:0]);
        mer_pkg::REG_CLIP_WIDTH:     cfg_r.clip_width    <= pwdata[mer_pkg::DIM_BITS-1:0];
        mer_pkg::REG_CLIP_HEIGHT:    cfg_r.clip_height   <= pwdata[mer_pkg::DIM_BITS-1:0];
        mer_pkg::REG_CANVAS_WIDTH:   cfg_r.canvas_width  <= pwdata[mer_pkg::DIM_BITS-1:0];
        mer_pkg::REG_CANVAS_HEIGHT:  cfg_r.canvas_height <= pwdata[mer_pkg::DIM_BITS-1:0];
        mer_pkg::REG_DRAW_COLOR:     cfg_r.draw_color    <= pwdata[mer_pkg::COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (idx)
      mer_pkg::REG_CLIP_LEFT:
        prdata = mer_pkg::CFG_DATA_BITS'(unsigned'(cfg_r.clip_left));
      mer_pkg::REG_CLIP_TOP:
        prdata = mer_pkg::CFG_DATA_BITS'(unsigned'(cfg_r.clip_top));
      mer_pkg::REG_CLIP_WIDTH:    prdata = mer_pkg::CFG_DATA_BITS'(cfg_r.clip_width);
      mer_pkg::REG_CLIP_HEIGHT:   prdata = mer_pkg::CFG_DATA_BITS'(cfg_r.clip_height);
      mer_pkg::REG_CANVAS_WIDTH:  prdata = mer_pkg::CFG_DATA_BITS'(cfg_r.canvas_width);
      mer_pkg::REG_CANVAS_HEIGHT: prdata = mer_pkg::CFG_DATA_BITS'(cfg_r.canvas_height);
      mer_pkg::REG_DRAW_COLOR:    prdata = mer_pkg::CFG_DATA_BITS'(cfg_r.draw_color);
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: hdl/mer_ctrl.sv
module mer_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic              in_filled,
  output logic              out_valid,
  input  logic              out_stall,
  input  mer_pkg::dp_stat_t stat,
  output mer_pkg::dp_cmd_t  cmd
);

  mer_pkg::ctrl_state_t state_r, state_nxt;
  mer_pkg::phase_t      phase_r, phase_nxt;
  logic                 mirror_r, mirror_nxt;
  logic                 fill_r, fill_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;
  logic                 busy_init;
  logic                 is_fill;
  logic                 cur_side;
  logic                 next_side;
  mer_pkg::phase_t      phase_inc;

  function automatic logic side_of(mer_pkg::phase_t p);
    side_of = (p == mer_pkg::PH_OCT2) || (p == mer_pkg::PH_OCT3) ||
              (p == mer_pkg::PH_OCT6) || (p == mer_pkg::PH_OCT7) ||
              (p == mer_pkg::PH_FILL_SIDE);
  endfunction

  // handshake
  assign busy_init = (state_r == mer_pkg::ST_SQUARE) || (state_r == mer_pkg::ST_PRODUCT) ||
                     (state_r == mer_pkg::ST_SETUP);
  assign in_stall  = busy_init || (out_valid_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // phase decode
  assign is_fill   = (phase_r == mer_pkg::PH_FILL_TOP) || (phase_r == mer_pkg::PH_FILL_SIDE);
  assign cur_side  = side_of(phase_r);
  assign phase_inc = mer_pkg::phase_t'(phase_r + 4'd1);
  assign next_side = side_of(phase_inc);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mer_pkg::ST_IDLE;
      phase_r     <= mer_pkg::PH_OCT1;
      mirror_r    <= 1'b0;
      fill_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      mirror_r    <= mirror_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    mirror_nxt = mirror_r;
    fill_nxt   = fill_r;
    cmd        = '0;
    cmd.cur_side = cur_side;
    unique case (state_r)
      mer_pkg::ST_IDLE, mer_pkg::ST_RUN: begin
        if (accept && (in_cmd == mer_pkg::CMD_START)) begin
          cmd.load   = 1'b1;
          fill_nxt   = in_filled;
          mirror_nxt = 1'b0;
          if (stat.empty_start) begin
            cmd.emit       = 1'b1;
            cmd.emit_empty = 1'b1;
            cmd.done       = 1'b1;
            state_nxt      = mer_pkg::ST_IDLE;
          end else begin
            state_nxt = mer_pkg::ST_SQUARE;
          end
        end else if (accept && (state_r == mer_pkg::ST_RUN)) begin
          cmd.emit  = 1'b1;
          cmd.span  = is_fill;
          cmd.neg_x = is_fill ? mirror_r : (phase_r >= mer_pkg::PH_OCT5);
          cmd.neg_y = (phase_r <= mer_pkg::PH_OCT2) || (phase_r >= mer_pkg::PH_OCT7);
          if (is_fill && !mirror_r) begin
            // same step, mirrored span comes next
            mirror_nxt = 1'b1;
          end else begin
            mirror_nxt = 1'b0;
            cmd.update = 1'b1;
            if (!stat.more) begin
              if ((phase_r == mer_pkg::PH_FILL_SIDE) ||
                  ((phase_r == mer_pkg::PH_OCT8) && !fill_r)) begin
                cmd.done  = 1'b1;
                state_nxt = mer_pkg::ST_IDLE;
              end else begin
                phase_nxt     = phase_inc;
                cmd.init      = 1'b1;
                cmd.init_side = next_side;
              end
            end
          end
        end
      end
      mer_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = mer_pkg::ST_PRODUCT;
      end
      mer_pkg::ST_PRODUCT: begin
        cmd.product = 1'b1;
        state_nxt   = mer_pkg::ST_SETUP;
      end
      mer_pkg::ST_SETUP: begin
        cmd.init      = 1'b1;
        cmd.init_side = 1'b0;
        phase_nxt     = mer_pkg::PH_OCT1;
        mirror_nxt    = 1'b0;
        state_nxt     = mer_pkg::ST_RUN;
      end
      default: state_nxt = mer_pkg::ST_IDLE;
    endcase
    out_valid_nxt = cmd.emit ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

endmodule

// File: hdl/mer_datapath.sv
module mer_datapath #(
  parameter int COORD_BITS = 16,
  parameter int AXIS_BITS  = 12
) (
  input  logic                                 clk,
  input  logic signed [COORD_BITS-1:0]         in_center_x,
  input  logic signed [COORD_BITS-1:0]         in_center_y,
  input  logic [AXIS_BITS-1:0]                 in_semi_a,
  input  logic [AXIS_BITS-1:0]                 in_semi_b,
  input  mer_pkg::cfg_t                        cfg,
  input  mer_pkg::dp_cmd_t                     cmd,
  output mer_pkg::dp_stat_t                    stat,
  output logic                                 out_visible,
  output logic                                 out_kind,
  output logic signed [COORD_BITS-1:0]         out_pos_x,
  output logic signed [COORD_BITS-1:0]         out_pos_y,
  output logic signed [COORD_BITS-1:0]         out_span_end_y,
  output logic [mer_pkg::COLOR_BITS-1:0]       out_color,
  output logic                                 out_done_res
);

  localparam int SQ_W  = 2 * AXIS_BITS;
  localparam int PR_W  = 3 * AXIS_BITS;
  localparam int SIX_W = SQ_W + 3;
  localparam int D_W   = PR_W + 5;
  localparam int S_W   = AXIS_BITS + 1;
  localparam int M_A   = (COORD_BITS > S_W + 1) ? COORD_BITS : S_W + 1;
  localparam int M_B   = (M_A > mer_pkg::CLIP_BITS + 1) ? M_A : mer_pkg::CLIP_BITS + 1;
  localparam int CMP_W = M_B + 1;
  localparam logic signed [CMP_W-1:0] ONE = CMP_W'(1);

  // held figure
  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic [AXIS_BITS-1:0]         a_r, b_r;
  logic [SQ_W-1:0]              a2_r, b2_r;
  logic [PR_W-1:0]              pa_r, qb_r;
  logic [SIX_W-1:0]             six_a2_r, six_b2_r;

  // running step state: p = b^2*x, q = a^2*y
  logic [S_W-1:0]               x_r, y_r;
  logic signed [D_W-1:0]        d_r, p_r, q_r;

  // result register
  logic                         vis_r, kind_r, done_r;
  logic signed [COORD_BITS-1:0] px_r, py_r, pe_r;
  logic [mer_pkg::COLOR_BITS-1:0] color_r;

  logic signed [D_W-1:0] a2_d, b2_d, six_a2_d, six_b2_d, pa_d, qb_d;
  logic signed [D_W-1:0] cond_v, step_v, d_upd, p_upd, q_upd;
  logic [S_W-1:0]        x_upd, y_upd;
  logic                  take;

  assign a2_d     = signed'(D_W'(a2_r));
  assign b2_d     = signed'(D_W'(b2_r));
  assign six_a2_d = signed'(D_W'(six_a2_r));
  assign six_b2_d = signed'(D_W'(six_b2_r));
  assign pa_d     = signed'(D_W'(pa_r));
  assign qb_d     = signed'(D_W'(qb_r));
  assign take     = !d_r[D_W-1];

  // one midpoint step with incremental products
  always_comb begin
    if (cmd.cur_side) begin
      cond_v = (b2_d <<< 2) - (p_r <<< 2);
      step_v = (q_r <<< 2) + six_a2_d;
      x_upd  = x_r - S_W'(take);
      y_upd  = y_r + S_W'(1);
      p_upd  = take ? (p_r - b2_d) : p_r;
      q_upd  = q_r + a2_d;
    end else begin
      cond_v = (a2_d <<< 2) - (q_r <<< 2);
      step_v = (p_r <<< 2) + six_b2_d;
      x_upd  = x_r + S_W'(1);
      y_upd  = y_r - S_W'(take);
      p_upd  = p_r + b2_d;
      q_upd  = take ? (q_r - a2_d) : q_r;
    end
    d_upd = d_r + (take ? cond_v : '0) + step_v;
  end

  assign stat.more        = cmd.cur_side ? (q_upd <= p_upd) : (p_upd <= q_upd);
  assign stat.empty_start = (in_semi_a == '0) || (in_semi_b == '0);

  // figure setup and step registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r <= in_center_x;
      cy_r <= in_center_y;
      a_r  <= in_semi_a;
      b_r  <= in_semi_b;
    end
    if (cmd.square) begin
      a2_r <= SQ_W'(a_r) * SQ_W'(a_r);
      b2_r <= SQ_W'(b_r) * SQ_W'(b_r);
    end
    if (cmd.product) begin
      pa_r     <= PR_W'(b2_r) * PR_W'(a_r);
      qb_r     <= PR_W'(a2_r) * PR_W'(b_r);
      six_a2_r <= (SIX_W'(a2_r) << 2) + (SIX_W'(a2_r) << 1);
      six_b2_r <= (SIX_W'(b2_r) << 2) + (SIX_W'(b2_r) << 1);
    end
    if (cmd.init) begin
      if (cmd.init_side) begin
        x_r <= S_W'(a_r);
        y_r <= '0;
        p_r <= pa_d;
        q_r <= '0;
        d_r <= (a2_d <<< 1) - (pa_d <<< 1);
      end else begin
        x_r <= '0;
        y_r <= S_W'(b_r);
        p_r <= '0;
        q_r <= qb_d;
        d_r <= (b2_d <<< 1) - (qb_d <<< 1);
      end
    end else if (cmd.update) begin
      x_r <= x_upd;
      y_r <= y_upd;
      p_r <= p_upd;
      q_r <= q_upd;
      d_r <= d_upd;
    end
  end

  // clip window and result coordinates
  logic                    use_canvas;
  logic signed [CMP_W-1:0] xl, xr, yt, yb;
  logic signed [CMP_W-1:0] cx_e, cy_e, x_e, y_e;
  logic signed [CMP_W-1:0] px, y_lo, y_hi, sy, top_c, bot_c;
  logic                    in_x, vis_pix, vis_span;

  assign use_canvas = (cfg.clip_width <= mer_pkg::DIM_BITS'(1)) ||
                      (cfg.clip_height <= mer_pkg::DIM_BITS'(1));
  assign xl = use_canvas ? '0 : CMP_W'(cfg.clip_left);
  assign yt = use_canvas ? '0 : CMP_W'(cfg.clip_top);
  assign xr = use_canvas ? signed'(CMP_W'(cfg.canvas_width)) - ONE
                         : CMP_W'(cfg.clip_left) + signed'(CMP_W'(cfg.clip_width)) - ONE;
  assign yb = use_canvas ? signed'(CMP_W'(cfg.canvas_height)) - ONE
                         : CMP_W'(cfg.clip_top) + signed'(CMP_W'(cfg.clip_height)) - ONE;

  assign cx_e  = CMP_W'(cx_r);
  assign cy_e  = CMP_W'(cy_r);
  assign x_e   = signed'(CMP_W'(x_r));
  assign y_e   = signed'(CMP_W'(y_r));
  assign px    = cmd.neg_x ? (cx_e - x_e) : (cx_e + x_e);
  assign y_lo  = cy_e - y_e;
  assign y_hi  = cy_e + y_e;
  assign sy    = cmd.neg_y ? y_lo : y_hi;
  assign top_c = (y_lo < yt) ? yt : y_lo;
  assign bot_c = (y_hi > yb) ? yb : y_hi;

  assign in_x     = (px >= xl) && (px <= xr);
  assign vis_pix  = in_x && (sy >= yt) && (sy <= yb);
  assign vis_span = in_x && (top_c <= bot_c);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      color_r <= cfg.draw_color;
      done_r  <= cmd.done;
      if (cmd.emit_empty) begin
        vis_r  <= 1'b0;
        kind_r <= 1'b0;
        px_r   <= in_center_x;
        py_r   <= in_center_y;
        pe_r   <= in_center_y;
      end else if (cmd.span) begin
        vis_r  <= vis_span;
        kind_r <= 1'b1;
        px_r   <= px[COORD_BITS-1:0];
        py_r   <= top_c[COORD_BITS-1:0];
        pe_r   <= bot_c[COORD_BITS-1:0];
      end else begin
        vis_r  <= vis_pix;
        kind_r <= 1'b0;
        px_r   <= px[COORD_BITS-1:0];
        py_r   <= sy[COORD_BITS-1:0];
        pe_r   <= sy[COORD_BITS-1:0];
      end
    end
  end

  assign out_visible    = vis_r;
  assign out_kind       = kind_r;
  assign out_pos_x      = px_r;
  assign out_pos_y      = py_r;
  assign out_span_end_y = pe_r;
  assign out_color      = color_r;
  assign out_done_res   = done_r;

endmodule

// File: hdl/midpoint_ellipse_rasterizer_core.sv
// channel   direction  handshake           payload
// in_       input      in_valid/in_stall   cmd, center_x, center_y, semi_a, semi_b, filled
// out_      output     out_valid/out_stall visible, kind, pos_x, pos_y, span_end_y, color,
//                                          done_res
// apb       input      psel/penable/pready clip window, canvas size, draw color
//
// an advance item gives its pixel or span in the cycle after acceptance; one item per cycle
// while the result register drains. a start item with nonzero axes holds in_stall through
// its setup states (squares, then axis products, then region setup).
// the result register lets a new item in at the edge that hands the held result over.
// reset (synchronous, active low) leaves the block idle with the default clip settings.
module midpoint_ellipse_rasterizer_core #(
  parameter int COORD_BITS = 16,
  parameter int AXIS_BITS  = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic signed [COORD_BITS-1:0]      in_center_x,
  input  logic signed [COORD_BITS-1:0]      in_center_y,
  input  logic [AXIS_BITS-1:0]              in_semi_a,
  input  logic [AXIS_BITS-1:0]              in_semi_b,
  input  logic                              in_filled,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_visible,
  output logic                              out_kind,
  output logic signed [COORD_BITS-1:0]      out_pos_x,
  output logic signed [COORD_BITS-1:0]      out_pos_y,
  output logic signed [COORD_BITS-1:0]      out_span_end_y,
  output logic [mer_pkg::COLOR_BITS-1:0]    out_color,
  output logic                              out_done_res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mer_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [mer_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [mer_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                              pready
);

  mer_pkg::cfg_t     cfg;
  mer_pkg::dp_cmd_t  cmd;
  mer_pkg::dp_stat_t stat;

  // configuration registers
  mer_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_filled (in_filled),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and result register
  mer_datapath #(
    .COORD_BITS (COORD_BITS),
    .AXIS_BITS  (AXIS_BITS)
  ) u_dp (
    .clk            (clk),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_semi_a      (in_semi_a),
    .in_semi_b      (in_semi_b),
    .cfg            (cfg),
    .cmd            (cmd),
    .stat           (stat),
    .out_visible    (out_visible),
    .out_kind       (out_kind),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_span_end_y (out_span_end_y),
    .out_color      (out_color),
    .out_done_res   (out_done_res)
  );

endmodule

// File: hdl/mer_checker.sv
`include "midpoint_ellipse_rasterizer_core_macros.svh"

module mer_checker #(
  parameter int COORD_BITS = 16,
  parameter int AXIS_BITS  = 12
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_cmd,
  input logic [AXIS_BITS-1:0]         in_semi_a,
  input logic [AXIS_BITS-1:0]         in_semi_b,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_visible,
  input logic                         out_kind,
  input logic signed [COORD_BITS-1:0] out_pos_x,
  input logic signed [COORD_BITS-1:0] out_pos_y,
  input logic signed [COORD_BITS-1:0] out_span_end_y,
  input logic                         out_done_res
);

  logic start_acc, empty_start;

  assign start_acc   = in_valid && !in_stall && (in_cmd == mer_pkg::CMD_START);
  assign empty_start = (in_semi_a == '0) || (in_semi_b == '0);

  // a held result does not move while stalled
  `MER_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_pos_x) && $stable(out_done_res))

  // outline pixels have a single row
  `MER_ASSERT_IMPLY(a_pixel_row, clk, rst_n, out_valid && !out_kind, out_span_end_y == out_pos_y)

  // an empty figure answers at once with a hidden final item
  `MER_ASSERT_NEXT(a_empty_fig, clk, rst_n, start_acc && empty_start, out_valid && out_done_res && !out_visible && !out_kind)

  // a real start produces nothing and blocks input while the figure is set up
  `MER_ASSERT_NEXT(a_start_setup, clk, rst_n, start_acc && !empty_start, !out_valid && in_stall)

endmodule

bind midpoint_ellipse_rasterizer_core mer_checker #(
  .COORD_BITS (COORD_BITS),
  .AXIS_BITS  (AXIS_BITS)
) u_mer_checker (.*);
